FILE: src/mia_pkg.sv
// Shared types, step codes and fixed-point helpers for the attitude update block.
package mia_pkg;

   localparam int QUAT_FRAC_BITS = 30;
   localparam int RATE_FRAC      = 24;
   localparam int GAIN_SHIFT     = QUAT_FRAC_BITS + 16 - RATE_FRAC;
   localparam int HALF_SHIFT     = RATE_FRAC + 24 + 1 - QUAT_FRAC_BITS;
   localparam int GYRO_SHIFT     = RATE_FRAC - 10;

   localparam logic signed [31:0] QUAT_ONE  = 32'sd1 <<< QUAT_FRAC_BITS;
   localparam logic signed [31:0] QUAT_HALF = 32'sd1 <<< (QUAT_FRAC_BITS - 1);

   localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
   localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

   // register indexes
   localparam logic [1:0] REG_PROP_GAIN     = 2'd0;
   localparam logic [1:0] REG_INTEGRAL_GAIN = 2'd1;
   localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

   // sequencer steps
   localparam logic [5:0] ST_NA0  = 6'd0;
   localparam logic [5:0] ST_NA1  = 6'd1;
   localparam logic [5:0] ST_NA2  = 6'd2;
   localparam logic [5:0] ST_SQA  = 6'd3;
   localparam logic [5:0] ST_DU0  = 6'd4;
   localparam logic [5:0] ST_DU1  = 6'd5;
   localparam logic [5:0] ST_DU2  = 6'd6;
   localparam logic [5:0] ST_HV0  = 6'd7;
   localparam logic [5:0] ST_HV1  = 6'd8;
   localparam logic [5:0] ST_HV2  = 6'd9;
   localparam logic [5:0] ST_HV3  = 6'd10;
   localparam logic [5:0] ST_HV4  = 6'd11;
   localparam logic [5:0] ST_HV5  = 6'd12;
   localparam logic [5:0] ST_HE0  = 6'd13;
   localparam logic [5:0] ST_HE1  = 6'd14;
   localparam logic [5:0] ST_HE2  = 6'd15;
   localparam logic [5:0] ST_HE3  = 6'd16;
   localparam logic [5:0] ST_HE4  = 6'd17;
   localparam logic [5:0] ST_HE5  = 6'd18;
   localparam logic [5:0] ST_IXT  = 6'd19;
   localparam logic [5:0] ST_IXI  = 6'd20;
   localparam logic [5:0] ST_IXP  = 6'd21;
   localparam logic [5:0] ST_IYT  = 6'd22;
   localparam logic [5:0] ST_IYI  = 6'd23;
   localparam logic [5:0] ST_IYP  = 6'd24;
   localparam logic [5:0] ST_IZT  = 6'd25;
   localparam logic [5:0] ST_IZI  = 6'd26;
   localparam logic [5:0] ST_IZP  = 6'd27;
   localparam logic [5:0] ST_H0   = 6'd28;
   localparam logic [5:0] ST_H1   = 6'd29;
   localparam logic [5:0] ST_H2   = 6'd30;
   localparam logic [5:0] ST_NQ00 = 6'd31;
   localparam logic [5:0] ST_NQ01 = 6'd32;
   localparam logic [5:0] ST_NQ02 = 6'd33;
   localparam logic [5:0] ST_NQ10 = 6'd34;
   localparam logic [5:0] ST_NQ11 = 6'd35;
   localparam logic [5:0] ST_NQ12 = 6'd36;
   localparam logic [5:0] ST_NQ20 = 6'd37;
   localparam logic [5:0] ST_NQ21 = 6'd38;
   localparam logic [5:0] ST_NQ22 = 6'd39;
   localparam logic [5:0] ST_NQ30 = 6'd40;
   localparam logic [5:0] ST_NQ31 = 6'd41;
   localparam logic [5:0] ST_NQ32 = 6'd42;
   localparam logic [5:0] ST_M0   = 6'd43;
   localparam logic [5:0] ST_M1   = 6'd44;
   localparam logic [5:0] ST_M2   = 6'd45;
   localparam logic [5:0] ST_M3   = 6'd46;
   localparam logic [5:0] ST_SQN  = 6'd47;
   localparam logic [5:0] ST_DN0  = 6'd48;
   localparam logic [5:0] ST_DN1  = 6'd49;
   localparam logic [5:0] ST_DN2  = 6'd50;
   localparam logic [5:0] ST_DN3  = 6'd51;

   typedef struct packed {
      logic [23:0] sample_period;
      logic [23:0] integral_gain_twice;
      logic [23:0] prop_gain_twice;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       issue;
      logic       apply;
      logic       start;
      logic       commit;
      logic [5:0] step;
   } cmd_type;

   typedef struct packed {
      logic accel_zero;
      logic igain_zero;
      logic root_zero;
      logic unit_done;
      logic out_free;
   } status_type;

   function automatic logic [1:0] step_lane(input logic [5:0] step);
      logic [1:0] l;
      case (step)
         ST_NA1, ST_DU1, ST_IYT, ST_IYI, ST_IYP, ST_H1, ST_M1, ST_DN1: l = 2'd1;
         ST_NA2, ST_DU2, ST_IZT, ST_IZI, ST_IZP, ST_H2, ST_M2, ST_DN2: l = 2'd2;
         ST_M3, ST_DN3:                                                l = 2'd3;
         default:                                                      l = 2'd0;
      endcase
      return l;
   endfunction

   function automatic logic [5:0] step_shift(input logic [5:0] step);
      logic [5:0] s;
      case (step)
         ST_IXT, ST_IYT, ST_IZT, ST_IXP, ST_IYP, ST_IZP: s = 6'(GAIN_SHIFT);
         ST_IXI, ST_IYI, ST_IZI:                         s = 6'd24;
         ST_H0, ST_H1, ST_H2:                            s = 6'(HALF_SHIFT);
         default:                                        s = 6'(QUAT_FRAC_BITS);
      endcase
      return s;
   endfunction

   function automatic logic signed [31:0] sat_wide(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) r = S32_MAX[31:0];
      else if (v < S32_MIN) r = S32_MIN[31:0];
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
      return sat_wide({{30{v[35]}}, v});
   endfunction

   function automatic logic signed [35:0] sx36(input logic signed [31:0] v);
      return {{4{v[31]}}, v};
   endfunction

   function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
      return {v[31], v};
   endfunction

   // round half away from zero, then saturate to 32 bits
   function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] x,
                                                  input logic [5:0] sh);
      logic        neg;
      logic [64:0] mag;
      logic [64:0] r;
      logic signed [65:0] v;
      neg = x[63];
      mag = {1'b0, (neg ? 64'(-x) : 64'(x))};
      r = (mag + (65'd1 << (sh - 6'd1))) >> sh;
      v = neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
      return sat_wide(v);
   endfunction

   function automatic logic signed [31:0] quo_sat(input logic [62:0] q, input logic neg);
      logic signed [65:0] v;
      v = neg ? -$signed({3'b0, q}) : $signed({3'b0, q});
      return sat_wide(v);
   endfunction

endpackage

FILE: src/mia_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module mia_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [62:0] dividend,
   input  logic [32:0] divisor,
   output logic [62:0] quotient,
   output logic        done
);
   logic [62:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;
   logic        ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[62]};
      ge      = trial >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 6'd62;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? 33'(trial - {1'b0, dvs_ff}) : trial[32:0];
         quo_in = {quo_ff[61:0], ge};
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

FILE: src/mia_sqrt.sv
// Digit-by-digit floor square root of a 64-bit value, one root bit per cycle.
module mia_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic [31:0] root,
   output logic        done
);
   logic [63:0] rad_ff, rad_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] rem_t;
   logic [34:0] trial;
   logic        ge;

   always_comb begin
      rem_t   = {rem_ff, rad_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      ge      = rem_t >= trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 5'd31;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = ge ? 33'(rem_t - trial) : rem_t[32:0];
         root_in = {root_ff[30:0], ge};
         rad_in  = {rad_ff[61:0], 2'b00};
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule

FILE: src/mia_datapath.sv
// Datapath: state registers, shared multiplier, accumulator, divider and square root.
module mia_datapath (
   input  logic                clock,
   input  logic                reset,
   input  mia_pkg::cfg_type    cfg,
   input  mia_pkg::cmd_type    cmd,
   output mia_pkg::status_type sts,
   input  logic [95:0]         req_tdata,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [127:0]        rsp_tdata
);
   import mia_pkg::*;

   logic signed [31:0] q_ff [4], q_in [4];
   logic signed [31:0] nq_ff [4], nq_in [4];
   logic signed [31:0] ifb_ff [3], ifb_in [3];
   logic signed [31:0] g_ff [3], g_in [3];
   logic signed [15:0] a_ff [3], a_in [3];
   logic signed [31:0] u_ff [3], u_in [3];
   logic signed [31:0] hv_ff [3], hv_in [3];
   logic signed [31:0] he_ff [3], he_in [3];
   logic signed [31:0] h_ff [3], h_in [3];
   logic signed [31:0] tmp_ff, tmp_in;
   logic signed [35:0] acc_ff, acc_in;
   logic [31:0]        nsum_ff, nsum_in;
   logic [63:0]        msum_ff, msum_in;
   logic [31:0]        s_ff, s_in;
   logic [31:0]        r_ff, r_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [1:0]         lane;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_full;
   logic signed [31:0] term;
   logic signed [31:0] ifb_new;
   logic               du_sel, sq_sel;
   logic [16:0]        a_mag;
   logic [32:0]        nq_mag;
   logic [62:0]        div_dividend;
   logic [32:0]        div_divisor;
   logic [62:0]        div_q;
   logic               div_done;
   logic [63:0]        sq_radicand;
   logic [31:0]        sq_root;
   logic               sq_done;
   logic [32:0]        pgain, igain, period;

   assign lane   = step_lane(cmd.step);
   assign pgain  = {9'b0, cfg.prop_gain_twice};
   assign igain  = {9'b0, cfg.integral_gain_twice};
   assign period = {9'b0, cfg.sample_period};
   assign du_sel = (cmd.step == ST_DU0) || (cmd.step == ST_DU1) || (cmd.step == ST_DU2);
   assign sq_sel = (cmd.step == ST_SQA) || (cmd.step == ST_SQN);

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         ST_NA0, ST_NA1, ST_NA2: begin
            mul_a = {{17{a_ff[lane][15]}}, a_ff[lane]};
            mul_b = mul_a;
         end
         ST_HV0: begin mul_a = sx33(q_ff[1]); mul_b = sx33(q_ff[3]); end
         ST_HV1: begin mul_a = sx33(q_ff[0]); mul_b = sx33(q_ff[2]); end
         ST_HV2: begin mul_a = sx33(q_ff[0]); mul_b = sx33(q_ff[1]); end
         ST_HV3: begin mul_a = sx33(q_ff[2]); mul_b = sx33(q_ff[3]); end
         ST_HV4: begin mul_a = sx33(q_ff[0]); mul_b = sx33(q_ff[0]); end
         ST_HV5: begin mul_a = sx33(q_ff[3]); mul_b = sx33(q_ff[3]); end
         ST_HE0: begin mul_a = sx33(u_ff[1]); mul_b = sx33(hv_ff[2]); end
         ST_HE1: begin mul_a = sx33(u_ff[2]); mul_b = sx33(hv_ff[1]); end
         ST_HE2: begin mul_a = sx33(u_ff[2]); mul_b = sx33(hv_ff[0]); end
         ST_HE3: begin mul_a = sx33(u_ff[0]); mul_b = sx33(hv_ff[2]); end
         ST_HE4: begin mul_a = sx33(u_ff[0]); mul_b = sx33(hv_ff[1]); end
         ST_HE5: begin mul_a = sx33(u_ff[1]); mul_b = sx33(hv_ff[0]); end
         ST_IXT, ST_IYT, ST_IZT: begin mul_a = igain; mul_b = sx33(he_ff[lane]); end
         ST_IXI, ST_IYI, ST_IZI: begin mul_a = sx33(tmp_ff); mul_b = period; end
         ST_IXP, ST_IYP, ST_IZP: begin mul_a = pgain; mul_b = sx33(he_ff[lane]); end
         ST_H0, ST_H1, ST_H2:    begin mul_a = sx33(g_ff[lane]); mul_b = period; end
         ST_NQ00: begin mul_a = sx33(q_ff[1]); mul_b = sx33(h_ff[0]); end
         ST_NQ01: begin mul_a = sx33(q_ff[2]); mul_b = sx33(h_ff[1]); end
         ST_NQ02: begin mul_a = sx33(q_ff[3]); mul_b = sx33(h_ff[2]); end
         ST_NQ10: begin mul_a = sx33(q_ff[0]); mul_b = sx33(h_ff[0]); end
         ST_NQ11: begin mul_a = sx33(q_ff[2]); mul_b = sx33(h_ff[2]); end
         ST_NQ12: begin mul_a = sx33(q_ff[3]); mul_b = sx33(h_ff[1]); end
         ST_NQ20: begin mul_a = sx33(q_ff[0]); mul_b = sx33(h_ff[1]); end
         ST_NQ21: begin mul_a = sx33(q_ff[1]); mul_b = sx33(h_ff[2]); end
         ST_NQ22: begin mul_a = sx33(q_ff[3]); mul_b = sx33(h_ff[0]); end
         ST_NQ30: begin mul_a = sx33(q_ff[0]); mul_b = sx33(h_ff[2]); end
         ST_NQ31: begin mul_a = sx33(q_ff[1]); mul_b = sx33(h_ff[1]); end
         ST_NQ32: begin mul_a = sx33(q_ff[2]); mul_b = sx33(h_ff[0]); end
         ST_M0, ST_M1, ST_M2, ST_M3: begin
            mul_a = sx33(nq_ff[lane]);
            mul_b = mul_a;
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign prod_in  = cmd.issue ? mul_full[63:0] : prod_ff;
   assign term     = rnd_sat(prod_ff, step_shift(cmd.step));
   assign ifb_new  = sat36(sx36(ifb_ff[lane]) + sx36(term));

   // operands for the iterative units
   always_comb begin
      a_mag  = a_ff[lane][15] ? 17'(-{a_ff[lane][15], a_ff[lane]})
                              : {a_ff[lane][15], a_ff[lane]};
      nq_mag = nq_ff[lane][31] ? 33'(-sx33(nq_ff[lane])) : sx33(nq_ff[lane]);
      if (du_sel) begin
         div_dividend = (63'(a_mag) << (QUAT_FRAC_BITS + 16)) + 63'(s_ff >> 1);
         div_divisor  = {1'b0, s_ff};
      end else begin
         div_dividend = (63'(nq_mag) << QUAT_FRAC_BITS) + 63'(r_ff);
         div_divisor  = {r_ff, 1'b0};
      end
      sq_radicand = (cmd.step == ST_SQA) ? {nsum_ff, 32'd0} : msum_ff;
   end

   mia_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start && !sq_sel),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .done     (div_done)
   );

   mia_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start && sq_sel),
      .radicand (sq_radicand),
      .root     (sq_root),
      .done     (sq_done)
   );

   always_comb begin
      q_in         = q_ff;
      nq_in        = nq_ff;
      ifb_in       = ifb_ff;
      g_in         = g_ff;
      a_in         = a_ff;
      u_in         = u_ff;
      hv_in        = hv_ff;
      he_in        = he_ff;
      h_in         = h_ff;
      tmp_in       = tmp_ff;
      acc_in       = acc_ff;
      nsum_in      = nsum_ff;
      msum_in      = msum_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.load) begin
         for (int i = 0; i < 3; i++) begin
            g_in[i] = $signed({{16{req_tdata[16*i+15]}}, req_tdata[16*i +: 16]}) <<< GYRO_SHIFT;
            a_in[i] = req_tdata[48+16*i +: 16];
         end
      end

      if (cmd.apply) begin
         case (cmd.step)
            ST_NA0, ST_NA1, ST_NA2:
               nsum_in = ((lane == 2'd0) ? 32'd0 : nsum_ff) + prod_ff[31:0];
            ST_SQA:
               s_in = sq_root;
            ST_DU0, ST_DU1, ST_DU2:
               u_in[lane] = quo_sat(div_q, a_ff[lane][15]);
            ST_HV0, ST_HV2, ST_HE0, ST_HE2, ST_HE4:
               acc_in = sx36(term);
            ST_HV4:
               acc_in = sx36(term) - sx36(QUAT_HALF);
            ST_HV1: hv_in[0] = sat36(acc_ff - sx36(term));
            ST_HV3: hv_in[1] = sat36(acc_ff + sx36(term));
            ST_HV5: hv_in[2] = sat36(acc_ff + sx36(term));
            ST_HE1: he_in[0] = sat36(acc_ff - sx36(term));
            ST_HE3: he_in[1] = sat36(acc_ff - sx36(term));
            ST_HE5: he_in[2] = sat36(acc_ff - sx36(term));
            ST_IXT, ST_IYT, ST_IZT:
               tmp_in = term;
            ST_IXI, ST_IYI, ST_IZI: begin
               ifb_in[lane] = ifb_new;
               g_in[lane]   = sat36(sx36(g_ff[lane]) + sx36(ifb_new));
            end
            ST_IXP, ST_IYP, ST_IZP: begin
               g_in[lane] = sat36(sx36(g_ff[lane]) + sx36(term));
               if (sts.igain_zero) ifb_in[lane] = '0;
            end
            ST_H0, ST_H1, ST_H2:
               h_in[lane] = term;
            ST_NQ00: acc_in = sx36(q_ff[0]) - sx36(term);
            ST_NQ01: acc_in = acc_ff - sx36(term);
            ST_NQ02: nq_in[0] = sat36(acc_ff - sx36(term));
            ST_NQ10: acc_in = sx36(q_ff[1]) + sx36(term);
            ST_NQ11: acc_in = acc_ff + sx36(term);
            ST_NQ12: nq_in[1] = sat36(acc_ff - sx36(term));
            ST_NQ20: acc_in = sx36(q_ff[2]) + sx36(term);
            ST_NQ21: acc_in = acc_ff - sx36(term);
            ST_NQ22: nq_in[2] = sat36(acc_ff + sx36(term));
            ST_NQ30: acc_in = sx36(q_ff[3]) + sx36(term);
            ST_NQ31: acc_in = acc_ff + sx36(term);
            ST_NQ32: nq_in[3] = sat36(acc_ff - sx36(term));
            ST_M0, ST_M1, ST_M2, ST_M3:
               msum_in = ((lane == 2'd0) ? 64'd0 : msum_ff) + {2'b00, prod_ff[63:2]};
            ST_SQN: begin
               r_in = sq_root;
               // degenerate magnitude falls back to identity
               if (sq_root == 32'd0) begin
                  nq_in[0] = QUAT_ONE;
                  nq_in[1] = '0;
                  nq_in[2] = '0;
                  nq_in[3] = '0;
               end
            end
            ST_DN0, ST_DN1, ST_DN2, ST_DN3:
               nq_in[lane] = quo_sat(div_q, nq_ff[lane][31]);
            default: acc_in = acc_ff;
         endcase
      end

      if (cmd.commit) begin
         q_in         = nq_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      nq_ff   <= nq_in;
      g_ff    <= g_in;
      a_ff    <= a_in;
      u_ff    <= u_in;
      hv_ff   <= hv_in;
      he_ff   <= he_in;
      h_ff    <= h_in;
      tmp_ff  <= tmp_in;
      acc_ff  <= acc_in;
      nsum_ff <= nsum_in;
      msum_ff <= msum_in;
      s_ff    <= s_in;
      r_ff    <= r_in;
      prod_ff <= prod_in;
      if (reset) begin
         q_ff[0]      <= QUAT_ONE;
         q_ff[1]      <= '0;
         q_ff[2]      <= '0;
         q_ff[3]      <= '0;
         ifb_ff[0]    <= '0;
         ifb_ff[1]    <= '0;
         ifb_ff[2]    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         q_ff         <= q_in;
         ifb_ff       <= ifb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.accel_zero = (a_ff[0] == 16'sd0) && (a_ff[1] == 16'sd0) && (a_ff[2] == 16'sd0);
   assign sts.igain_zero = cfg.integral_gain_twice == 24'd0;
   assign sts.root_zero  = sq_root == 32'd0;
   assign sts.unit_done  = sq_sel ? sq_done : div_done;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {q_ff[3], q_ff[2], q_ff[1], q_ff[0]};
endmodule

FILE: src/mia_ctrl.sv
// Sequencer: walks the update steps and drives the datapath commands.
module mia_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  mia_pkg::status_type sts,
   output mia_pkg::cmd_type    cmd
);
   import mia_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_ISSUE    = 3'd2;
   localparam logic [2:0] S_APPLY    = 3'd3;
   localparam logic [2:0] S_START    = 3'd4;
   localparam logic [2:0] S_WAIT     = 3'd5;
   localparam logic [2:0] S_COMMIT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic [5:0] nxt;

   function automatic logic is_unit(input logic [5:0] s);
      return (s == ST_SQA) || (s == ST_SQN) || (s == ST_DU0) || (s == ST_DU1) ||
             (s == ST_DU2) || (s == ST_DN0) || (s == ST_DN1) || (s == ST_DN2) ||
             (s == ST_DN3);
   endfunction

   always_comb begin
      nxt = step_ff + 6'd1;
      // no integral term: skip straight to the proportional step
      if (sts.igain_zero && ((nxt == ST_IXT) || (nxt == ST_IYT) || (nxt == ST_IZT)))
         nxt = nxt + 6'd2;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            step_in  = sts.accel_zero ? ST_H0 : ST_NA0;
            state_in = S_ISSUE;
         end
         S_ISSUE: state_in = S_APPLY;
         S_START: state_in = S_WAIT;
         S_WAIT: begin
            if (sts.unit_done) state_in = S_APPLY;
         end
         S_APPLY: begin
            if ((step_ff == ST_DN3) || ((step_ff == ST_SQN) && sts.root_zero)) begin
               state_in = S_COMMIT;
            end else begin
               step_in  = nxt;
               state_in = is_unit(nxt) ? S_START : S_ISSUE;
            end
         end
         S_COMMIT: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign cmd.load   = req_tvalid && (state_ff == S_IDLE);
   assign cmd.issue  = state_ff == S_ISSUE;
   assign cmd.apply  = state_ff == S_APPLY;
   assign cmd.start  = state_ff == S_START;
   assign cmd.commit = (state_ff == S_COMMIT) && sts.out_free;
   assign cmd.step   = step_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("commit while result register occupied");

   a_load_dispatch: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_DISPATCH)
      else $error("accepted transaction not dispatched");

   a_issue_apply: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> cmd.apply && $stable(cmd.step))
      else $error("product not applied on following cycle");

   a_unit_step: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> is_unit(cmd.step))
      else $error("unit started on a multiply step");
endmodule

FILE: src/mahony_imu_attitude_update.sv
// Top level of the Mahony IMU attitude update: configuration registers, sequencer and datapath.
//
// req channel: one transaction carries a gyro and accelerometer sample; req_tready is high
// only while the block is idle. rsp channel: one transaction per sample carries the
// renormalised quaternion (Q2.30). csr channel: always ready; writes one 24-bit register
// (index 0 twice Kp, 1 twice Ki, 2 sample period; index 3 ignored). Write it only when idle.
//
// A zero accelerometer reading skips the correction steps, zero integral gain skips the
// integral steps, and a degenerate quaternion skips the final divisions. The bit-serial
// divider (up to seven divisions) and the square root dominate; the remaining steps use
// one shared 33x33 multiplier. The next sample is taken at the edge after the result is
// placed in the output register.
//
// Reset (synchronous, active high) restores the registers to their defaults, the
// quaternion to identity and the integrators to zero. When the receiver stalls the result
// stays in the output register; a following sample is worked on but not committed
// until the earlier transaction has been taken.
module mahony_imu_attitude_update (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // quat_w, quat_x, quat_y, quat_z
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_data
);
   import mia_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type sts;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PROP_GAIN:     cfg_in.prop_gain_twice     = csr_data;
            REG_INTEGRAL_GAIN: cfg_in.integral_gain_twice = csr_data;
            REG_SAMPLE_PERIOD: cfg_in.sample_period       = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain_twice     <= 24'd65536;
         cfg_ff.integral_gain_twice <= 24'd0;
         cfg_ff.sample_period       <= 24'd32768;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   mia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mia_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
